// ===== rtl/tcfh_pkg.sv =====
// Shared types and constants for the two-choice fingerprint hash table.
`default_nettype none
package tcfh_pkg;
	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	localparam logic [31:0] HASH_MUL0    = 32'ha8134c35;
	localparam logic [31:0] HASH_MUL1    = 32'he626c2d3;
	localparam logic [31:0] FOLD_HI_MASK = 32'hffff0000;
	localparam logic [31:0] FOLD_LO_MASK = 32'h0000ffff;

	// hashed command handed from front to back
	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] key;
		logic [12:0] value;
		logic [63:0] z0;
		logic [63:0] z1;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_stat_t;

	typedef enum logic [1:0] {FR_IDLE, FR_MUL0, FR_MUL1, FR_PUSH} front_state_t;

	typedef enum logic [2:0] {
		BK_CLEAR, BK_IDLE, BK_RD0, BK_RD1, BK_DECIDE, BK_SCAN, BK_KCHK, BK_RESP
	} back_state_t;
endpackage
`default_nettype wire

// ===== rtl/tcfh_front.sv =====
// Front end: takes an item, folds the key and forms both hash products.
`default_nettype none
module tcfh_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [1:0]     in_mode,
	input  wire logic [63:0]    in_key,
	input  wire logic [12:0]    in_value,
	output logic                push_valid,
	output tcfh_pkg::cmd_t      push_cmd,
	input  wire logic           q_full
);
	tcfh_pkg::front_state_t state_q, state_d;
	logic [1:0]  mode_q;
	logic [63:0] key_q;
	logic [12:0] value_q;
	logic [63:0] z0_q, z1_q;
	logic [31:0] fold, mul_c;
	logic [63:0] prod;

	// x ^ y; the upper half of y is always zero
	assign fold = ((32'(key_q >> 16) & tcfh_pkg::FOLD_HI_MASK)
		| (32'(key_q) & tcfh_pkg::FOLD_LO_MASK))
		^ (32'(key_q >> 16) & tcfh_pkg::FOLD_LO_MASK);
	assign mul_c = (state_q == tcfh_pkg::FR_MUL1) ? tcfh_pkg::HASH_MUL1 : tcfh_pkg::HASH_MUL0;
	assign prod  = 64'(fold) * 64'(mul_c);

	assign in_ready   = (state_q == tcfh_pkg::FR_IDLE);
	assign push_valid = (state_q == tcfh_pkg::FR_PUSH);
	assign push_cmd   = '{mode: mode_q, key: key_q, value: value_q, z0: z0_q, z1: z1_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcfh_pkg::FR_IDLE: if (in_valid) state_d = tcfh_pkg::FR_MUL0;
			tcfh_pkg::FR_MUL0: state_d = tcfh_pkg::FR_MUL1;
			tcfh_pkg::FR_MUL1: state_d = tcfh_pkg::FR_PUSH;
			tcfh_pkg::FR_PUSH: if (!q_full) state_d = tcfh_pkg::FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcfh_pkg::FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcfh_pkg::FR_IDLE && in_valid) begin
			mode_q  <= in_mode;
			key_q   <= in_key;
			value_q <= in_value;
		end
		if (state_q == tcfh_pkg::FR_MUL0) z0_q <= prod;
		if (state_q == tcfh_pkg::FR_MUL1) z1_q <= prod;
	end
endmodule
`default_nettype wire

// ===== rtl/tcfh_queue.sv =====
// Two-entry command queue between front and back.
`default_nettype none
module tcfh_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	input  wire tcfh_pkg::cmd_t push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output tcfh_pkg::cmd_t      head,
	output logic [1:0]          level
);
	tcfh_pkg::cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] level_q;
	logic push, take;

	assign full  = (level_q == 2'd2);
	assign empty = (level_q == 2'd0);
	assign head  = mem_q[rp_q];
	assign level = level_q;
	assign push  = push_valid && !full;
	assign take  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			level_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (take) rp_q <= ~rp_q;
			if (push && !take) level_q <= level_q + 2'd1;
			else if (take && !push) level_q <= level_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_cmd;
	end
endmodule
`default_nettype wire

// ===== rtl/tcfh_back.sv =====
// Back end: bucket and key stores, insert/lookup/remove sequencer, result register.
`default_nettype none
module tcfh_back #(
	parameter int BUCKETS_PER_HALF = 1024,
	parameter int SLOTS_PER_BUCKET = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire tcfh_pkg::cmd_t q_head,
	output tcfh_pkg::back_stat_t stat,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [12:0]         out_found,
	output logic                out_ok
);
	localparam int BW   = $clog2(BUCKETS_PER_HALF);
	localparam int VW   = BW + 3;
	localparam int SW   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int CW   = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int RW   = BW + 1;
	localparam int ROWS = 2 * BUCKETS_PER_HALF;
	localparam int KEYS = 8 * BUCKETS_PER_HALF;
	localparam logic [31:0] VMASK  = 32'(8 * BUCKETS_PER_HALF - 1);
	localparam logic [31:0] FPMASK = ~VMASK;

	// bit 32 of a slot is its valid flag
	typedef logic [SLOTS_PER_BUCKET-1:0][32:0] row_t;

	row_t        row_mem [ROWS];
	logic [63:0] key_mem [KEYS];

	tcfh_pkg::back_state_t state_q, state_d;
	tcfh_pkg::cmd_t cmd_q;
	row_t        row0_q, row1_q, row_rd_q;
	logic [63:0] key_rd_q;
	logic        half_q;
	logic [SW-1:0] slot_q;
	logic [RW-1:0] clr_q;
	logic [12:0] found_q;
	logic        ok_q;
	logic        out_valid_q, out_ok_q;
	logic [12:0] out_found_q;

	logic [BW-1:0] bkt0, bkt1;
	logic [31:0] fp0, fp1, val_m, cur_fp;
	row_t        cur_row, wr_row;
	logic [32:0] cur_ent;
	logic        hit, last;
	logic [CW-1:0] n0, n1;
	logic [SW-1:0] j0, j1;
	logic        pop, rd_en, wr_en, k_wr_en, k_rd_en, res_set, res_ok, adv, scan_go;
	logic [RW-1:0] rd_addr, wr_addr;
	logic [12:0] res_found;

	assign bkt0  = cmd_q.z0[32 +: BW];
	assign bkt1  = cmd_q.z1[32 +: BW];
	assign fp0   = 32'(cmd_q.z0 >> 29) & FPMASK;
	assign fp1   = 32'(cmd_q.z1 >> 29) & FPMASK;
	assign val_m = 32'(cmd_q.value) & VMASK;

	assign cur_row = half_q ? row1_q : row0_q;
	assign cur_ent = cur_row[slot_q];
	assign cur_fp  = half_q ? fp1 : fp0;
	assign hit     = cur_ent[32] && ((cur_ent[31:0] & FPMASK) == cur_fp);
	assign last    = half_q && (slot_q == SW'(SLOTS_PER_BUCKET - 1));

	// free slots per bucket; last free slot wins
	always_comb begin
		n0 = '0;
		n1 = '0;
		j0 = '0;
		j1 = '0;
		for (int k = 0; k < SLOTS_PER_BUCKET; k++) begin
			if (!row0_q[k][32]) begin
				n0 = n0 + CW'(1);
				j0 = SW'(k);
			end
			if (!row_rd_q[k][32]) begin
				n1 = n1 + CW'(1);
				j1 = SW'(k);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_row    = '0;
		k_wr_en   = 1'b0;
		k_rd_en   = 1'b0;
		res_set   = 1'b0;
		res_found = '0;
		res_ok    = 1'b0;
		adv       = 1'b0;
		scan_go   = 1'b0;
		unique case (state_q)
			tcfh_pkg::BK_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == RW'(ROWS - 1)) state_d = tcfh_pkg::BK_IDLE;
			end
			tcfh_pkg::BK_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = tcfh_pkg::BK_RD0;
				end
			end
			tcfh_pkg::BK_RD0: begin
				rd_en   = 1'b1;
				rd_addr = {1'b0, bkt0};
				state_d = tcfh_pkg::BK_RD1;
			end
			tcfh_pkg::BK_RD1: begin
				rd_en   = 1'b1;
				rd_addr = {1'b1, bkt1};
				state_d = tcfh_pkg::BK_DECIDE;
			end
			tcfh_pkg::BK_DECIDE: begin
				if (cmd_q.mode == tcfh_pkg::MODE_INSERT) begin
					res_set = 1'b1;
					state_d = tcfh_pkg::BK_RESP;
					if (n0 != '0 || n1 != '0) begin
						k_wr_en = 1'b1;
						wr_en   = 1'b1;
						res_ok  = 1'b1;
						if (n0 >= n1) begin
							wr_addr    = {1'b0, bkt0};
							wr_row     = row0_q;
							wr_row[j0] = {1'b1, fp0 | val_m};
						end else begin
							wr_addr    = {1'b1, bkt1};
							wr_row     = row_rd_q;
							wr_row[j1] = {1'b1, fp1 | val_m};
						end
					end
				end else if (cmd_q.mode == tcfh_pkg::MODE_LOOKUP
						|| cmd_q.mode == tcfh_pkg::MODE_REMOVE) begin
					scan_go = 1'b1;
					state_d = tcfh_pkg::BK_SCAN;
				end else begin
					res_set = 1'b1;
					state_d = tcfh_pkg::BK_RESP;
				end
			end
			tcfh_pkg::BK_SCAN: begin
				if (hit) begin
					k_rd_en = 1'b1;
					state_d = tcfh_pkg::BK_KCHK;
				end else if (last) begin
					res_set = 1'b1;
					state_d = tcfh_pkg::BK_RESP;
				end else begin
					adv = 1'b1;
				end
			end
			tcfh_pkg::BK_KCHK: begin
				if (key_rd_q == cmd_q.key) begin
					res_set = 1'b1;
					res_ok  = 1'b1;
					state_d = tcfh_pkg::BK_RESP;
					if (cmd_q.mode == tcfh_pkg::MODE_LOOKUP) begin
						res_found = 13'(cur_ent[31:0] & VMASK);
					end else begin
						wr_en          = 1'b1;
						wr_addr        = {half_q, half_q ? bkt1 : bkt0};
						wr_row         = cur_row;
						wr_row[slot_q] = '0;
					end
				end else if (last) begin
					res_set = 1'b1;
					state_d = tcfh_pkg::BK_RESP;
				end else begin
					adv     = 1'b1;
					state_d = tcfh_pkg::BK_SCAN;
				end
			end
			tcfh_pkg::BK_RESP: begin
				if (!out_valid_q || out_ready) state_d = tcfh_pkg::BK_IDLE;
			end
		endcase
	end

	assign stat      = '{clearing: (state_q == tcfh_pkg::BK_CLEAR), pop: pop};
	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_ok    = out_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcfh_pkg::BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tcfh_pkg::BK_CLEAR) clr_q <= clr_q + RW'(1);
			if (state_q == tcfh_pkg::BK_RESP && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= q_head;
		if (state_q == tcfh_pkg::BK_RD1) row0_q <= row_rd_q;
		if (state_q == tcfh_pkg::BK_DECIDE) row1_q <= row_rd_q;
		if (scan_go) begin
			half_q <= 1'b0;
			slot_q <= '0;
		end else if (adv) begin
			if (slot_q == SW'(SLOTS_PER_BUCKET - 1)) begin
				half_q <= 1'b1;
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + SW'(1);
			end
		end
		if (res_set) begin
			found_q <= res_found;
			ok_q    <= res_ok;
		end
		if (state_q == tcfh_pkg::BK_RESP && (!out_valid_q || out_ready)) begin
			out_found_q <= found_q;
			out_ok_q    <= ok_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) row_mem[wr_addr] <= wr_row;
		if (rd_en) row_rd_q <= row_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (k_wr_en) key_mem[val_m[VW-1:0]] <= cmd_q.key;
		if (k_rd_en) key_rd_q <= key_mem[cur_ent[VW-1:0]];
	end
endmodule
`default_nettype wire

// ===== rtl/two_choice_fingerprint_hash_table.sv =====
// Two-choice fingerprint hash table: 64-bit keys to 13-bit value indices.
// Front takes a new item only once the last one is pushed (fold, two products, push); push waits on a full queue.
// Back reads both candidate buckets, then decides for insert or unused mode; lookup/remove scan
// one slot at a time (up to 2*SLOTS_PER_BUCKET) with a key check on each fingerprint hit.
// Reset clears all 2*BUCKETS_PER_HALF buckets of the bucket store, one bucket per cycle; items queue.
`default_nettype none
module two_choice_fingerprint_hash_table #(
	parameter int BUCKETS_PER_HALF = 1024,
	parameter int SLOTS_PER_BUCKET = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // key [63:0], value [76:64], zero [79:77]
	input  wire logic [1:0]  s_tuser,  // mode [1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // found_value [12:0], zero [15:13]
	output logic [0:0]       m_tuser   // success [0]
);
	logic           push_valid, q_full, q_empty;
	tcfh_pkg::cmd_t push_cmd, q_head;
	logic [1:0]     q_level;
	tcfh_pkg::back_stat_t bk_stat;
	logic [12:0]    found;
	logic           ok;

	// hashing side
	tcfh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_mode    (s_tuser),
		.in_key     (s_tdata[63:0]),
		.in_value   (s_tdata[76:64]),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.q_full     (q_full)
	);

	// decouples hashing from table access
	tcfh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (bk_stat.pop),
		.empty      (q_empty),
		.head       (q_head),
		.level      (q_level)
	);

	// table access and result register
	tcfh_back #(
		.BUCKETS_PER_HALF (BUCKETS_PER_HALF),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.stat       (bk_stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_found  (found),
		.out_ok     (ok)
	);

	assign m_tdata = {3'b000, found};
	assign m_tuser = ok;

`ifndef SYNTHESIS
	// nothing leaves the queue while the bucket store is being cleared
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.clearing |-> !bk_stat.pop) else $error("pop during clear");
	// queue never exceeds two items
	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_level != 2'd3) else $error("queue overflow");
	// back handles one item at a time
	a_single_pop: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.pop |=> !bk_stat.pop) else $error("back popped twice");
	// front holds one item while hashing it
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("front took two items");
`endif
endmodule
`default_nettype wire
